// ===== rtl/core/egsd_pkg.sv =====
package egsd_pkg;

    // Element kinds after classification
    typedef enum logic [2:0] {
        KIND_UE   = 3'd0,
        KIND_SE   = 3'd1,
        KIND_FIX  = 3'd2,
        KIND_PEEK = 3'd3,
        KIND_CBP  = 3'd4,
        KIND_NONE = 3'd5
    } egsd_kind_t;

    // Request codes on the input channel
    localparam logic [2:0] REQ_UE   = 3'd0;
    localparam logic [2:0] REQ_SE   = 3'd1;
    localparam logic [2:0] REQ_FIX  = 3'd2;
    localparam logic [2:0] REQ_PEEK = 3'd3;
    localparam logic [2:0] REQ_CBP  = 3'd4;

    localparam int WINDOW_BITS  = 40;
    localparam int ALIGN_BITS   = 32;
    localparam int PREFIX_BITS  = 16;
    localparam int CBP_CODES    = 48;
    localparam int VALUE_BITS   = 33;

    // Intra cbp map, indexed by ue code
    localparam logic [5:0] CBP_INTRA_MAP [CBP_CODES] = '{
        6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
        6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
        6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
        6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
        6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
        6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
    };

    // One classified item waiting for the back end
    typedef struct packed {
        egsd_kind_t              kind;
        logic [ALIGN_BITS-1:0]   bits;        // window aligned to the element start
        logic [3:0]              zeros;       // leading zero count of the prefix
        logic                    prefix_err;  // more than 15 leading zeros
        logic [5:0]              len;         // saturated field length
        logic [2:0]              off;         // starting bit offset
    } egsd_entry_t;

endpackage

// ===== rtl/core/egsd_front.sv =====
module egsd_front
    import egsd_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic [2:0]               req_type,
    input  logic [WINDOW_BITS-1:0]   stream_window,
    input  logic [2:0]               bit_offset,
    input  logic [5:0]               field_length,
    output egsd_entry_t              entry
);

    localparam logic [5:0] MAX_LEN = 6'(MAX_FIELD_BITS);

    logic [WINDOW_BITS-1:0] aligned;
    logic [PREFIX_BITS-1:0] prefix;
    logic [3:0]             zeros;
    logic                   found;
    egsd_kind_t             kind;

    // Align the window so the element starts at the MSB
    assign aligned = stream_window << bit_offset;
    assign prefix  = aligned[WINDOW_BITS-1 -: PREFIX_BITS];

    // Leading zero count over the prefix bits
    always_comb begin
        zeros = '0;
        found = 1'b0;
        for (int i = 0; i < PREFIX_BITS; i++) begin
            if (!found && prefix[PREFIX_BITS-1-i]) begin
                zeros = 4'(i);
                found = 1'b1;
            end
        end
    end

    // Request classification
    always_comb begin
        unique case (req_type)
            REQ_UE:   kind = KIND_UE;
            REQ_SE:   kind = KIND_SE;
            REQ_FIX:  kind = KIND_FIX;
            REQ_PEEK: kind = KIND_PEEK;
            REQ_CBP:  kind = KIND_CBP;
            default:  kind = KIND_NONE;
        endcase
    end

    always_comb begin
        entry.kind       = kind;
        entry.bits       = aligned[WINDOW_BITS-1 -: ALIGN_BITS];
        entry.zeros      = zeros;
        entry.prefix_err = ~found;
        entry.len        = (field_length > MAX_LEN) ? MAX_LEN : field_length;
        entry.off        = bit_offset;
    end

endmodule

// ===== rtl/core/egsd_queue.sv =====
module egsd_queue
    import egsd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  egsd_entry_t  push_entry,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output egsd_entry_t  head
);

    egsd_entry_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("push lost in queue");

endmodule

// ===== rtl/core/egsd_back.sv =====
module egsd_back
    import egsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    input  egsd_entry_t            head,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [32:0]     m_value,
    output logic [2:0]             m_bytes_advanced,
    output logic [2:0]             m_new_bit_offset,
    output logic                   m_decode_error
);

    logic                  valid_reg, valid_next;
    logic [32:0]           value_reg, value_next;
    logic [2:0]            bytes_reg, bytes_next;
    logic [2:0]            offset_reg, offset_next;
    logic                  error_reg, error_next;

    logic [ALIGN_BITS-1:0] ue_raw;
    logic [15:0]           code;
    logic [16:0]           mag_sum;
    logic [32:0]           mag;
    logic [ALIGN_BITS-1:0] fix_val;
    logic [5:0]            used;
    logic [5:0]            end_pos;

    // Take the next item when the output register is free or being drained
    assign pop = q_not_empty && (!valid_reg || m_ready);

    // Exp-Golomb code: codeword bits from the leading one, minus one
    assign ue_raw  = head.bits >> (5'd31 - {head.zeros, 1'b0});
    assign code    = ue_raw[15:0] - 16'd1;
    assign mag_sum = {1'b0, code} + 17'd1;
    assign mag     = {17'b0, mag_sum[16:1]};
    assign fix_val = (head.len == 6'd0) ? '0 : (head.bits >> (6'd32 - head.len));

    // Element decode
    always_comb begin
        value_next = '0;
        used       = '0;
        error_next = 1'b0;
        unique case (head.kind) inside
            KIND_UE, KIND_SE, KIND_CBP: begin
                if (head.prefix_err) begin
                    error_next = 1'b1;
                end else begin
                    used = {1'b0, head.zeros, 1'b1};
                    if (head.kind == KIND_UE) begin
                        value_next = {17'b0, code};
                    end else if (head.kind == KIND_SE) begin
                        value_next = code[0] ? mag : (33'd0 - mag);
                    end else if (code < 16'(CBP_CODES)) begin
                        value_next = {27'b0, CBP_INTRA_MAP[code[5:0]]};
                    end else begin
                        error_next = 1'b1;
                    end
                end
            end
            KIND_FIX: begin
                value_next = {1'b0, fix_val};
                used       = head.len;
            end
            KIND_PEEK: begin
                value_next = {1'b0, fix_val};
            end
            default: begin
                value_next = '0;
            end
        endcase
    end

    assign end_pos     = {3'b0, head.off} + used;
    assign bytes_next  = end_pos[5:3];
    assign offset_next = end_pos[2:0];

    // Output valid
    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            value_reg  <= value_next;
            bytes_reg  <= bytes_next;
            offset_reg <= offset_next;
            error_reg  <= error_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_value          = signed'(value_reg);
    assign m_bytes_advanced = bytes_reg;
    assign m_new_bit_offset = offset_reg;
    assign m_decode_error   = error_reg;

    a_pop_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> valid_reg)
        else $error("popped item not presented");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && error_reg |-> value_reg == '0)
        else $error("error result carries a value");

endmodule

// ===== rtl/core/exp_golomb_syntax_decoder_unit.sv =====
// Channel   Ports                                                  Direction
// input     s_valid s_ready s_req_type s_stream_window             in
//           s_bit_offset s_field_length
// result    m_valid m_ready m_value m_bytes_advanced               out
//           m_new_bit_offset m_decode_error
//
// One item per cycle sustained unless the output stalls.
// The front end aligns and classifies in the accept cycle, the back end decodes into
// the output register. A two-entry queue between them absorbs output stalls.
// aresetn is synchronous, active low, and empties the queue and the output register.
// s_ready drops only while the queue is full.
module exp_golomb_syntax_decoder_unit
    import egsd_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_req_type,
    input  logic [39:0]          s_stream_window,
    input  logic [2:0]           s_bit_offset,
    input  logic [5:0]           s_field_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [32:0]   m_value,
    output logic [2:0]           m_bytes_advanced,
    output logic [2:0]           m_new_bit_offset,
    output logic                 m_decode_error
);

    egsd_entry_t front_entry;
    egsd_entry_t head;
    logic        q_full;
    logic        q_not_empty;
    logic        pop;
    logic        push;

    assign s_ready = ~q_full;
    assign push    = s_valid && s_ready;

    // Align, count prefix zeros, classify
    egsd_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_front (
        .req_type      (s_req_type),
        .stream_window (s_stream_window),
        .bit_offset    (s_bit_offset),
        .field_length  (s_field_length),
        .entry         (front_entry)
    );

    // Decoupling queue
    egsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    // Decode and output register
    egsd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_not_empty      (q_not_empty),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_bytes_advanced (m_bytes_advanced),
        .m_new_bit_offset (m_new_bit_offset),
        .m_decode_error   (m_decode_error)
    );

    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_full |-> s_ready)
        else $error("input stalled with queue room");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import egsd_pkg::*;

    // Request codes the block ignores
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    localparam int FIELD_BITS_MAX = 32;
    localparam int PREFIX_LIMIT   = 15;
    localparam int CBP_ENTRIES    = 48;
    localparam int CYCLE_LIMIT    = 200000;

    // Intra cbp value for each ue code
    localparam logic [5:0] INTRA_CBP_OF_CODE [CBP_ENTRIES] = '{
        6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
        6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
        6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
        6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
        6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
        6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
    };

    typedef struct packed {
        logic [32:0] value;
        logic [2:0]  bytes_adv;
        logic [2:0]  bit_off;
        logic        err;
    } element_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_req_type = REQ_UE;
    logic [39:0]        s_stream_window = '0;
    logic [2:0]         s_bit_offset = '0;
    logic [5:0]         s_field_length = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [32:0] m_value;
    logic [2:0]         m_bytes_advanced;
    logic [2:0]         m_new_bit_offset;
    logic               m_decode_error;

    element_t pending_elements[$];
    int send_idle_pct = 27;
    int recv_idle_pct = 45;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int errors_flagged = 0;
    int unknown_requests = 0;
    int cycle_count = 0;

    exp_golomb_syntax_decoder_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_stream_window  (s_stream_window),
        .s_bit_offset     (s_bit_offset),
        .s_field_length   (s_field_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_bytes_advanced (m_bytes_advanced),
        .m_new_bit_offset (m_new_bit_offset),
        .m_decode_error   (m_decode_error)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Expected element for one request
    function automatic element_t decode_element(logic [2:0] kind, logic [39:0] win,
                                                logic [2:0] off, logic [5:0] flen);
        element_t   r;
        int         n;
        int         z;
        int         used;
        int         endp;
        logic [39:0] aligned;
        logic [39:0] rest;
        logic [63:0] code;
        logic [63:0] mag;
        logic [63:0] val;
        logic        err;
        n = (flen > FIELD_BITS_MAX) ? FIELD_BITS_MAX : int'(flen);
        aligned = win << off;
        val = '0;
        used = 0;
        err = 1'b0;
        case (kind) inside
            REQ_UE, REQ_SE, REQ_CBP: begin
                z = 0;
                while (z <= PREFIX_LIMIT && aligned[39 - z] == 1'b0) z++;
                if (z > PREFIX_LIMIT) begin
                    err = 1'b1;
                end else begin
                    rest = aligned << (z + 1);
                    code = ((64'd1 << z) - 64'd1) + (rest >> (40 - z));
                    used = 2 * z + 1;
                    if (kind == REQ_UE) begin
                        val = code;
                    end else if (kind == REQ_SE) begin
                        mag = (code + 64'd1) >> 1;
                        val = code[0] ? mag : (64'd0 - mag);
                    end else if (code < CBP_ENTRIES) begin
                        val = 64'(INTRA_CBP_OF_CODE[code]);
                    end else begin
                        // well-formed code outside the table: consumed, flagged
                        err = 1'b1;
                    end
                end
            end
            REQ_FIX: begin
                val = aligned >> (40 - n);
                used = n;
            end
            REQ_PEEK: val = aligned >> (40 - n);
            default: ;
        endcase
        endp = int'(off) + used;
        r.value = val[32:0];
        r.bytes_adv = 3'(endp >> 3);
        r.bit_off = 3'(endp);
        r.err = err;
        return r;
    endfunction

    // Random window with a codeword of the given prefix length at off;
    // a prefix beyond the limit is written as a run of zeros only
    function automatic logic [39:0] place_code(int zeros, logic [15:0] suffix, int off);
        logic [63:0] noise;
        logic [39:0] field;
        logic [39:0] cw;
        int          width;
        noise = {$urandom, $urandom};
        width = (zeros > PREFIX_LIMIT) ? zeros : 2 * zeros + 1;
        if (off + width > 40) width = 40 - off;
        field = ((40'd1 << width) - 40'd1) << (40 - off - width);
        if (zeros > PREFIX_LIMIT)
            cw = '0;
        else
            cw = ((40'd1 << zeros) | (suffix & ((40'd1 << zeros) - 40'd1)))
                 << (40 - off - width);
        return (noise[39:0] & ~field) | cw;
    endfunction

    function automatic logic [39:0] random_window();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return noise[39:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Offer one item, with random idle cycles first, and wait for acceptance
    task automatic send_item(logic [2:0] kind, logic [39:0] win, logic [2:0] off,
                             logic [5:0] flen);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_stream_window <= win;
        s_bit_offset <= off;
        s_field_length <= flen;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the input side idle until every result is back
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_elements.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_elements.push_back(
                decode_element(s_req_type, s_stream_window, s_bit_offset, s_field_length));
            items_sent++;
            if (s_req_type >= REQ_UNUSED_FIRST) unknown_requests++;
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin
        element_t exp_el;
        if (aresetn && m_valid && m_ready) begin
            if (pending_elements.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                exp_el = pending_elements.pop_front();
                results_checked++;
                if (exp_el.err) errors_flagged++;
                if (m_value !== exp_el.value)
                    report_mismatch($sformatf("value %h, expected %h", m_value, exp_el.value));
                if (m_bytes_advanced !== exp_el.bytes_adv)
                    report_mismatch($sformatf("bytes_advanced %0d, expected %0d",
                                              m_bytes_advanced, exp_el.bytes_adv));
                if (m_new_bit_offset !== exp_el.bit_off)
                    report_mismatch($sformatf("new_bit_offset %0d, expected %0d",
                                              m_new_bit_offset, exp_el.bit_off));
                if (m_decode_error !== exp_el.err)
                    report_mismatch($sformatf("decode_error %b, expected %b",
                                              m_decode_error, exp_el.err));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     pending_elements.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_ue_codes();
        send_item(REQ_UE, 40'hFF_FFFF_FFFF, 3'd0, 6'd0);
        send_item(REQ_UE, place_code(15, 16'hFFFF, 7), 3'd7, 6'd63);
        send_item(REQ_UE, place_code(15, 16'h0000, 0), 3'd0, 6'd21);
        send_item(REQ_UE, place_code(8, 16'($urandom), 5), 3'd5, 6'd42);
    endtask

    task automatic test_se_codes();
        send_item(REQ_SE, place_code(0, 16'h0, 2), 3'd2, 6'd0);
        send_item(REQ_SE, place_code(1, 16'h0, 4), 3'd4, 6'd0);
        send_item(REQ_SE, place_code(1, 16'h1, 6), 3'd6, 6'd0);
        // most negative and most positive values
        send_item(REQ_SE, place_code(15, 16'h7FFF, 7), 3'd7, 6'd0);
        send_item(REQ_SE, place_code(15, 16'h7FFE, 1), 3'd1, 6'd0);
    endtask

    task automatic test_fixed_reads();
        send_item(REQ_FIX, random_window(), 3'd3, 6'd0);
        send_item(REQ_FIX, 40'hFF_FFFF_FFFF, 3'd7, 6'd32);
        send_item(REQ_FIX, random_window(), 3'd0, 6'd63);
        send_item(REQ_FIX, random_window(), 3'd7, 6'd1);
    endtask

    task automatic test_peek();
        send_item(REQ_PEEK, 40'hFF_FFFF_FFFF, 3'd7, 6'd32);
        send_item(REQ_PEEK, random_window(), 3'd5, 6'd0);
        send_item(REQ_PEEK, random_window(), 3'd3, 6'd33);
    endtask

    task automatic test_cbp_map();
        send_item(REQ_CBP, place_code(0, 16'h0, 0), 3'd0, 6'd0);
        send_item(REQ_CBP, place_code(5, 16'd16, 3), 3'd3, 6'd0);
        // codes just past the table and at the top of the five-zero range
        send_item(REQ_CBP, place_code(5, 16'd17, 6), 3'd6, 6'd0);
        send_item(REQ_CBP, place_code(5, 16'd31, 7), 3'd7, 6'd0);
    endtask

    task automatic test_errors_and_unknown();
        send_item(REQ_UE, place_code(16, 16'h0, 7), 3'd7, 6'd10);
        send_item(REQ_SE, 40'h00_0000_0000, 3'd0, 6'd0);
        send_item(REQ_CBP, place_code(20, 16'h0, 2), 3'd2, 6'd5);
        send_item(REQ_UNUSED_FIRST, random_window(), 3'd4, 6'd16);
        send_item(REQ_UNUSED_FIRST + 3'd1, random_window(), 3'd1, 6'd32);
        send_item(REQ_UNUSED_LAST, random_window(), 3'd7, 6'd63);
    endtask

    // Mostly well-formed codewords with random content, plus reads and noise
    task automatic test_random_elements(int count);
        int          pick;
        int          z;
        logic [2:0]  kind;
        logic [2:0]  off;
        logic [5:0]  flen;
        logic [39:0] win;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            off = 3'($urandom);
            flen = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(32));
            case ($urandom_range(2))
                0: kind = REQ_UE;
                1: kind = REQ_SE;
                default: kind = REQ_CBP;
            endcase
            if (pick < 60) begin
                if (kind == REQ_CBP)
                    z = $urandom_range(6);
                else
                    z = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(7);
                win = place_code(z, 16'($urandom), off);
            end else if (pick < 85) begin
                kind = $urandom_range(1) ? REQ_FIX : REQ_PEEK;
                win = random_window();
            end else if (pick < 92) begin
                win = place_code($urandom_range(16, 33 - off), 16'h0, off);
            end else begin
                kind = 3'($urandom);
                win = random_window();
            end
            send_item(kind, win, off, flen);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ue_codes();
        test_se_codes();
        test_fixed_reads();
        test_peek();
        test_cbp_map();
        test_errors_and_unknown();
        wait_all_results();

        test_random_elements(430);
        wait_all_results();

        send_idle_pct = 45;
        recv_idle_pct = 27;
        test_random_elements(430);
        wait_all_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_elements(440);
        wait_all_results();
        repeat (8) @(posedge aclk);

        if (pending_elements.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_elements.size()));
        $display("%0d items sent (%0d with unused request codes), %0d results checked",
                 items_sent, unknown_requests, results_checked);
        $display("%0d results carried a decode error, %0d mismatches",
                 errors_flagged, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
